@@ hdl/spectral_peak_rpm_estimator_defines.svh @@
// assertion macros for the spectral peak rpm estimator
// both expect clk and rst_n in scope
`ifndef SPECTRAL_PEAK_RPM_ESTIMATOR_DEFINES_SVH
`define SPECTRAL_PEAK_RPM_ESTIMATOR_DEFINES_SVH

// same-cycle implication
`define SPRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/spre_pkg.sv @@
`default_nettype none
package spre_pkg;

  localparam int BIN_INDEX_BITS_DEF = 12;
  localparam int MAG_BITS_DEF       = 24;

  localparam int FRAC_BITS      = 16;
  localparam int DIV_EXTRA_BITS = 18;
  localparam int RPM_SHIFT      = 28;
  localparam int RPM_W          = 32;
  localparam int OFFSET_W       = 18;
  localparam int OFFSET_LIMIT   = 65536;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_BAND_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RPM_PER_BIN = 2'd2;

  localparam int                    BAND_LOW_RESET    = 5;
  localparam int                    BAND_HIGH_RESET   = 50;
  localparam logic [CFG_DATA_W-1:0] RPM_PER_BIN_RESET = 32'd3932160;

  typedef struct packed {
    logic bin_accept;
    logic prep;
    logic div_step;
    logic post;
    logic mul_lo;
    logic mul_hi;
    logic acc;
    logic finish;
  } spre_cmd_t;

  typedef struct packed {
    logic do_div;
  } spre_status_t;

endpackage
`default_nettype wire

@@ hdl/spre_divider.sv @@
`default_nettype none
module spre_divider #(
  parameter int NUM_W = spre_pkg::MAG_BITS_DEF + spre_pkg::DIV_EXTRA_BITS,
  parameter int DEN_W = spre_pkg::MAG_BITS_DEF + 3
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             step,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quotient
);

  logic [NUM_W-1:0] work_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_shift;
  logic             fits;

  // restoring division, one quotient bit per step
  assign rem_shift = {rem_r, work_r[NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (load) begin
      work_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (step) begin
      rem_r  <= fits ? DEN_W'(rem_shift - {1'b0, den_r}) : rem_shift[DEN_W-1:0];
      work_r <= {work_r[NUM_W-2:0], fits};
    end
  end

  assign quotient = work_r;

endmodule
`default_nettype wire

@@ hdl/spre_datapath.sv @@
`default_nettype none
`include "spectral_peak_rpm_estimator_defines.svh"
module spre_datapath #(
  parameter int BIN_INDEX_BITS = spre_pkg::BIN_INDEX_BITS_DEF,
  parameter int MAG_BITS       = spre_pkg::MAG_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire spre_pkg::spre_cmd_t                 cmd,
  output spre_pkg::spre_status_t                   status,
  input  wire logic [MAG_BITS-1:0]                 magnitude,
  input  wire logic                                last_bin,
  input  wire logic [BIN_INDEX_BITS-1:0]           band_low,
  input  wire logic [BIN_INDEX_BITS-1:0]           band_high,
  input  wire logic [spre_pkg::CFG_DATA_W-1:0]     rpm_per_bin,
  output logic      [spre_pkg::RPM_W-1:0]          rpm_x16,
  output logic      [BIN_INDEX_BITS-1:0]           peak_bin,
  output logic      [MAG_BITS-1:0]                 peak_magnitude,
  output logic signed [spre_pkg::OFFSET_W-1:0]     bin_offset_q16,
  output logic                                     interpolated
);

  localparam int B      = BIN_INDEX_BITS;
  localparam int M      = MAG_BITS;
  localparam int FB     = spre_pkg::FRAC_BITS;
  localparam int OW     = spre_pkg::OFFSET_W;
  localparam int NUM_W  = M + spre_pkg::DIV_EXTRA_BITS;
  localparam int DEN_W  = M + 3;
  localparam int REF_W  = B + FB + 1;
  localparam int HALF_W = spre_pkg::CFG_DATA_W / 2;
  localparam int PROD_W = REF_W + HALF_W;
  localparam int ACC_W  = REF_W + spre_pkg::CFG_DATA_W;
  localparam logic signed [OW-1:0] OffLimit = OW'(spre_pkg::OFFSET_LIMIT);

  // search state
  logic [B-1:0] bin_cnt_r;
  logic [M-1:0] best_mag_r;
  logic [B-1:0] best_idx_r;
  logic [M-1:0] prev_mag_r;
  logic [M-1:0] left_r;
  logic [M-1:0] right_r;
  logic         right_pend_r;
  logic         right_seen_r;
  logic         early_r;

  // end of frame
  logic [B-1:0]           fin_bin_r;
  logic [M-1:0]           fin_mag_r;
  logic                   interp_r;
  logic                   neg_r;
  logic signed [OW-1:0]   offset_r;
  logic [REF_W-1:0]       refined_r;
  logic [PROD_W-1:0]      prod_r;
  logic [ACC_W-1:0]       acc_r;

  logic [spre_pkg::RPM_W-1:0] out_rpm_r;
  logic [B-1:0]               out_bin_r;
  logic [M-1:0]               out_mag_r;
  logic signed [OW-1:0]       out_off_r;
  logic                       out_interp_r;

  logic               take;
  logic signed [M:0]  diff_s;
  logic signed [M+2:0] den_s;
  logic [M:0]         diff_abs;
  logic [M+2:0]       den_abs;
  logic [M+1:0]       ud;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [NUM_W-1:0]   quotient;
  logic [FB:0]        q_mag;
  logic signed [OW-1:0] off_mag;
  logic signed [OW-1:0] off_val;
  logic signed [REF_W-1:0] off_ext;
  logic [HALF_W-1:0]  mul_b;
  logic [ACC_W-1:0]   rpm_full;

  assign take = (bin_cnt_r == band_low) ||
                (bin_cnt_r > band_low && bin_cnt_r <= band_high && magnitude > best_mag_r);

  // curvature and divider operands
  assign diff_s   = $signed({1'b0, left_r}) - $signed({1'b0, right_r});
  assign den_s    = $signed({3'b000, left_r}) + $signed({3'b000, right_r})
                  - $signed({2'b00, best_mag_r, 1'b0});
  assign diff_abs = diff_s[M] ? (M+1)'(-diff_s) : diff_s;
  assign den_abs  = den_s[M+2] ? (M+3)'(-den_s) : den_s;
  assign ud       = {den_abs[M:0], 1'b0};
  assign div_num  = NUM_W'({diff_abs[M-1:0], {(FB+1){1'b0}}}) + NUM_W'(ud);
  assign div_den  = {ud, 1'b0};

  assign status.do_div = !early_r && best_idx_r != '0 && right_seen_r && den_s != '0;

  spre_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_divider (
    .clk      (clk),
    .load     (cmd.prep),
    .step     (cmd.div_step),
    .num      (div_num),
    .den      (div_den),
    .quotient (quotient)
  );

  // saturate to one bin, then apply sign
  assign q_mag   = (quotient > NUM_W'(spre_pkg::OFFSET_LIMIT)) ?
                   (FB+1)'(spre_pkg::OFFSET_LIMIT) : quotient[FB:0];
  assign off_mag = $signed({1'b0, q_mag});
  assign off_val = interp_r ? (neg_r ? -off_mag : off_mag) : '0;
  assign off_ext = REF_W'(offset_r);

  assign mul_b    = cmd.mul_lo ? rpm_per_bin[HALF_W-1:0] : rpm_per_bin[2*HALF_W-1:HALF_W];
  assign rpm_full = acc_r >> spre_pkg::RPM_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r    <= '0;
      best_mag_r   <= '0;
      best_idx_r   <= B'(spre_pkg::BAND_LOW_RESET);
      prev_mag_r   <= '0;
      left_r       <= '0;
      right_r      <= '0;
      right_pend_r <= 1'b0;
      right_seen_r <= 1'b0;
      early_r      <= 1'b0;
    end else if (cmd.finish) begin
      bin_cnt_r    <= '0;
      best_mag_r   <= '0;
      best_idx_r   <= band_low;
      prev_mag_r   <= '0;
      left_r       <= '0;
      right_r      <= '0;
      right_pend_r <= 1'b0;
      right_seen_r <= 1'b0;
    end else if (cmd.bin_accept) begin
      if (take) begin
        best_idx_r   <= bin_cnt_r;
        best_mag_r   <= magnitude;
        left_r       <= prev_mag_r;
        right_pend_r <= 1'b1;
        right_seen_r <= 1'b0;
      end else if (right_pend_r) begin
        right_r      <= magnitude;
        right_seen_r <= 1'b1;
        right_pend_r <= 1'b0;
      end
      if (!last_bin) begin
        prev_mag_r <= magnitude;
        bin_cnt_r  <= bin_cnt_r + 1'b1;
      end else begin
        early_r <= bin_cnt_r < band_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      fin_bin_r <= early_r ? band_low : best_idx_r;
      fin_mag_r <= early_r ? '0 : best_mag_r;
      interp_r  <= status.do_div;
      neg_r     <= diff_s[M] ^ den_s[M+2];
    end
    if (cmd.post) begin
      offset_r  <= off_val;
      refined_r <= {1'b0, fin_bin_r, {FB{1'b0}}} + REF_W'(off_val);
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod_r <= PROD_W'(refined_r) * PROD_W'(mul_b);
    end
    if (cmd.mul_hi) begin
      acc_r <= ACC_W'(prod_r);
    end
    if (cmd.acc) begin
      acc_r <= acc_r + (ACC_W'(prod_r) << HALF_W);
    end
    if (cmd.finish) begin
      out_rpm_r    <= (|rpm_full[ACC_W-1:spre_pkg::RPM_W]) ? '1 :
                      rpm_full[spre_pkg::RPM_W-1:0];
      out_bin_r    <= fin_bin_r;
      out_mag_r    <= fin_mag_r;
      out_off_r    <= offset_r;
      out_interp_r <= interp_r;
    end
  end

  assign rpm_x16        = out_rpm_r;
  assign peak_bin       = out_bin_r;
  assign peak_magnitude = out_mag_r;
  assign bin_offset_q16 = out_off_r;
  assign interpolated   = out_interp_r;

  `SPRE_ASSERT_NEXT(a_off_plain, cmd.post && !interp_r, offset_r == '0 && off_ext == '0, "offset without correction")
  `SPRE_ASSERT_NEXT(a_off_range, cmd.post, offset_r <= OffLimit && offset_r >= -OffLimit, "offset beyond one bin")

endmodule
`default_nettype wire

@@ hdl/spre_ctrl.sv @@
`default_nettype none
`include "spectral_peak_rpm_estimator_defines.svh"
module spre_ctrl #(
  parameter int DIV_STEPS = spre_pkg::MAG_BITS_DEF + spre_pkg::DIV_EXTRA_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_last_bin,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output spre_pkg::spre_cmd_t         cmd,
  input  wire spre_pkg::spre_status_t status
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_SEARCH,
    ST_PREP,
    ST_DIV,
    ST_POST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_SEARCH: begin
        cmd.bin_accept = in_valid;
        if (in_valid && in_last_bin) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep    = 1'b1;
        div_cnt_nxt = CNT_W'(DIV_STEPS - 1);
        state_nxt   = status.do_div ? ST_DIV : ST_POST;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = ST_POST;
        end else begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end
      ST_POST: begin
        cmd.post  = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_SEARCH;
        end
      end
      default: begin
        state_nxt = ST_SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEARCH;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  assign in_stall  = state_r != ST_SEARCH;
  assign out_valid = out_valid_r;

  `SPRE_ASSERT_NOW(a_result_src, $rose(out_valid_r), $past(state_r) == ST_FINISH, "result not from finish")
  `SPRE_ASSERT_NEXT(a_div_end, state_r == ST_DIV && div_cnt_r == '0, state_r == ST_POST, "divider overran")
  `SPRE_ASSERT_NEXT(a_frame_end, state_r == ST_SEARCH && in_valid && in_last_bin, state_r == ST_PREP && in_stall, "last bin missed")

endmodule
`default_nettype wire

@@ hdl/spectral_peak_rpm_estimator.sv @@
`default_nettype none
// Spectral peak RPM estimator. Magnitude bins of one spectrum enter one beat per cycle,
// bin 0 first, with in_last_bin on the final bin; the peak search inside the band
// [band_low_bin, band_high_bin] keeps pace with the bins. After the final bin the input
// stalls while one result is worked out: a setup step, then the shift-subtract divider
// when a parabolic correction applies, then the steps for the two 16-bit partial products
// of the rpm scaling and the output load, which waits while the previous result still
// sits unclaimed in the output register. Registers are written at cfg_index 0 (band low),
// 1 (band high) and 2 (rpm per bin, Q16.16); other indexes are ignored, and cfg_ready is
// always high.
module spectral_peak_rpm_estimator #(
  parameter int BIN_INDEX_BITS = spre_pkg::BIN_INDEX_BITS_DEF,
  parameter int MAG_BITS       = spre_pkg::MAG_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [MAG_BITS-1:0]                 in_magnitude,
  input  wire logic                                in_last_bin,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [spre_pkg::RPM_W-1:0]          out_rpm_x16,
  output logic      [BIN_INDEX_BITS-1:0]           out_peak_bin,
  output logic      [MAG_BITS-1:0]                 out_peak_magnitude,
  output logic signed [spre_pkg::OFFSET_W-1:0]     out_bin_offset_q16,
  output logic                                     out_interpolated,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [spre_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [spre_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DivSteps = MAG_BITS + spre_pkg::DIV_EXTRA_BITS;

  logic [BIN_INDEX_BITS-1:0]       band_low_r;
  logic [BIN_INDEX_BITS-1:0]       band_high_r;
  logic [spre_pkg::CFG_DATA_W-1:0] rpm_per_bin_r;

  spre_pkg::spre_cmd_t    cmd;
  spre_pkg::spre_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r    <= BIN_INDEX_BITS'(spre_pkg::BAND_LOW_RESET);
      band_high_r   <= BIN_INDEX_BITS'(spre_pkg::BAND_HIGH_RESET);
      rpm_per_bin_r <= spre_pkg::RPM_PER_BIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spre_pkg::REG_BAND_LOW:    band_low_r    <= cfg_data[BIN_INDEX_BITS-1:0];
        spre_pkg::REG_BAND_HIGH:   band_high_r   <= cfg_data[BIN_INDEX_BITS-1:0];
        spre_pkg::REG_RPM_PER_BIN: rpm_per_bin_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  spre_ctrl #(
    .DIV_STEPS (DivSteps)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_bin (in_last_bin),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status)
  );

  spre_datapath #(
    .BIN_INDEX_BITS (BIN_INDEX_BITS),
    .MAG_BITS       (MAG_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .magnitude      (in_magnitude),
    .last_bin       (in_last_bin),
    .band_low       (band_low_r),
    .band_high      (band_high_r),
    .rpm_per_bin    (rpm_per_bin_r),
    .rpm_x16        (out_rpm_x16),
    .peak_bin       (out_peak_bin),
    .peak_magnitude (out_peak_magnitude),
    .bin_offset_q16 (out_bin_offset_q16),
    .interpolated   (out_interpolated)
  );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int BIN_W         = spre_pkg::BIN_INDEX_BITS_DEF;
  localparam int MAG_W         = spre_pkg::MAG_BITS_DEF;
  localparam int IDLE_MAX      = 5;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int RUN_LIMIT     = 300000;

  localparam logic [spre_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [spre_pkg::RPM_W-1:0]    rpm;
    logic [BIN_W-1:0]              bin;
    logic [MAG_W-1:0]              mag;
    logic [spre_pkg::OFFSET_W-1:0] offset;
    logic                          interp;
  } rpm_beat_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [MAG_W-1:0]                     in_magnitude = '0;
  logic                                 in_last_bin = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [spre_pkg::RPM_W-1:0]           out_rpm_x16;
  logic [BIN_W-1:0]                     out_peak_bin;
  logic [MAG_W-1:0]                     out_peak_magnitude;
  logic signed [spre_pkg::OFFSET_W-1:0] out_bin_offset_q16;
  logic                                 out_interpolated;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [spre_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [spre_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  // predictor copy of the registers and the per-spectrum state
  logic [BIN_W-1:0]                lo_bin_cfg = BIN_W'(spre_pkg::BAND_LOW_RESET);
  logic [BIN_W-1:0]                hi_bin_cfg = BIN_W'(spre_pkg::BAND_HIGH_RESET);
  logic [spre_pkg::CFG_DATA_W-1:0] scale_cfg  = spre_pkg::RPM_PER_BIN_RESET;
  logic [BIN_W-1:0]                bin_pos    = '0;
  logic [MAG_W-1:0]                top_mag    = '0;
  logic [BIN_W-1:0]                top_bin    = BIN_W'(spre_pkg::BAND_LOW_RESET);
  logic [MAG_W-1:0]                last_mag   = '0;
  logic [MAG_W-1:0]                left_mag   = '0;
  logic [MAG_W-1:0]                right_mag  = '0;
  bit                              right_wanted = 1'b0;
  bit                              right_got    = 1'b0;

  rpm_beat_t expected_rpm_q[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        idling = 1'b1;
  int        hold_ticket = 0;
  int        hold_served = 0;
  int        hold_left = 0;
  int        stall_left = 0;

  spectral_peak_rpm_estimator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_magnitude       (in_magnitude),
    .in_last_bin        (in_last_bin),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rpm_x16        (out_rpm_x16),
    .out_peak_bin       (out_peak_bin),
    .out_peak_magnitude (out_peak_magnitude),
    .out_bin_offset_q16 (out_bin_offset_q16),
    .out_interpolated   (out_interpolated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic void clear_spectrum();
    bin_pos      = '0;
    top_mag      = '0;
    top_bin      = lo_bin_cfg;
    last_mag     = '0;
    left_mag     = '0;
    right_mag    = '0;
    right_wanted = 1'b0;
    right_got    = 1'b0;
  endfunction

  function automatic void track_bin(input logic [MAG_W-1:0] mag, input logic last);
    rpm_beat_t         r;
    bit                hit;
    bit                neg;
    longint            lm, pm, rm, curve, num, den2, q, offset, pbin;
    longint unsigned   un, ud, refined, scale_hi, scale_lo, scaled;
    hit = (bin_pos == lo_bin_cfg) ||
          (bin_pos > lo_bin_cfg && bin_pos <= hi_bin_cfg && mag > top_mag);
    if (hit) begin
      top_bin      = bin_pos;
      top_mag      = mag;
      left_mag     = last_mag;
      right_wanted = 1'b1;
      right_got    = 1'b0;
    end else if (right_wanted) begin
      right_mag    = mag;
      right_got    = 1'b1;
      right_wanted = 1'b0;
    end
    if (!last) begin
      last_mag = mag;
      bin_pos  = bin_pos + 1'b1;
      return;
    end
    r.bin    = top_bin;
    r.mag    = top_mag;
    r.interp = 1'b0;
    offset   = 0;
    if (bin_pos < lo_bin_cfg) begin
      // spectrum ended before the band began
      r.bin = lo_bin_cfg;
      r.mag = '0;
    end else if (top_bin != 0 && right_got) begin
      lm    = 64'(left_mag);
      pm    = 64'(top_mag);
      rm    = 64'(right_mag);
      curve = lm - 2 * pm + rm;
      if (curve != 0) begin
        num    = (lm - rm) * 65536;
        den2   = curve * 2;
        neg    = (num < 0) != (den2 < 0);
        un     = (num < 0) ? -num : num;
        ud     = (den2 < 0) ? -den2 : den2;
        q      = (un * 2 + ud) / (ud * 2);
        offset = neg ? -q : q;
        if (offset > spre_pkg::OFFSET_LIMIT) offset = spre_pkg::OFFSET_LIMIT;
        if (offset < -spre_pkg::OFFSET_LIMIT) offset = -spre_pkg::OFFSET_LIMIT;
        r.interp = 1'b1;
      end
    end
    pbin     = 64'(r.bin);
    refined  = pbin * 65536 + offset;
    scale_hi = 64'(scale_cfg[31:16]);
    scale_lo = 64'(scale_cfg[15:0]);
    scaled   = (refined * scale_hi + ((refined * scale_lo) >> 16)) >> 12;
    r.rpm    = (scaled > 64'hFFFF_FFFF) ? '1 : scaled[spre_pkg::RPM_W-1:0];
    r.offset = offset[spre_pkg::OFFSET_W-1:0];
    expected_rpm_q.push_back(r);
    clear_spectrum();
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result side: per-beat random stall plus a long hold on request
  always @(posedge clk) begin
    rpm_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_ticket != hold_served) begin
        hold_served = hold_ticket;
        hold_left   = LONG_HOLD;
      end
      if (out_valid && !out_stall) begin
        if (expected_rpm_q.size() == 0) begin
          $error("result beat with nothing expected: peak_bin %0d", out_peak_bin);
          mismatch_count++;
        end else begin
          want = expected_rpm_q.pop_front();
          check_field("rpm_x16", want.rpm, out_rpm_x16);
          check_field("peak_bin", want.bin, out_peak_bin);
          check_field("peak_magnitude", want.mag, out_peak_magnitude);
          check_field("bin_offset_q16", want.offset, $unsigned(out_bin_offset_q16));
          check_field("interpolated", want.interp, out_interpolated);
        end
        stall_left = idling ? $urandom_range(0, IDLE_MAX) : 0;
      end
      out_stall <= (hold_left > 0) || (stall_left > 0);
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last);
    int gap;
    gap = idling ? $urandom_range(0, IDLE_MAX) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_magnitude <= mag;
    in_last_bin  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_bin(mag, last);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_rpm_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_beat(input logic [spre_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [spre_pkg::CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      spre_pkg::REG_BAND_LOW:    lo_bin_cfg = data[BIN_W-1:0];
      spre_pkg::REG_BAND_HIGH:   hi_bin_cfg = data[BIN_W-1:0];
      spre_pkg::REG_RPM_PER_BIN: scale_cfg  = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [BIN_W-1:0] low, input logic [BIN_W-1:0] high,
                            input logic [spre_pkg::CFG_DATA_W-1:0] scale,
                            input bit poke_spare);
    write_beat(spre_pkg::REG_BAND_LOW, spre_pkg::CFG_DATA_W'(low));
    write_beat(spre_pkg::REG_BAND_HIGH, spre_pkg::CFG_DATA_W'(high));
    write_beat(spre_pkg::REG_RPM_PER_BIN, scale);
    if (poke_spare) write_beat(REG_SPARE, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // reset band, spectrum too short to reach it
  task automatic test_reset_config();
    send_bin(MAG_W'($urandom()), 1'b0);
    send_bin(MAG_W'($urandom()), 1'b0);
    send_bin(MAG_W'($urandom()), 1'b1);
  endtask

  // peak on bin 0 and peak on the final bin, full-scale values
  task automatic test_edge_peaks();
    wait_idle();
    set_config('0, '1, '1, 1'b1);
    send_bin('1, 1'b0);
    send_bin(24'd5, 1'b1);
    send_bin(24'd1, 1'b0);
    send_bin(24'd2, 1'b0);
    send_bin('1, 1'b1);
  endtask

  // zero curvature with right neighbour outside band, then an empty band
  task automatic test_flat_and_empty();
    wait_idle();
    set_config(12'd1, 12'd3, spre_pkg::RPM_PER_BIN_RESET, 1'b0);
    send_bin(24'd0, 1'b0);
    send_bin(24'd10, 1'b0);
    send_bin(24'd20, 1'b0);
    send_bin(24'd30, 1'b0);
    send_bin(24'd40, 1'b1);
    wait_idle();
    set_config(12'd3, 12'd1, $urandom(), 1'b0);
    send_bin(24'd50, 1'b0);
    send_bin(24'd60, 1'b0);
    send_bin(24'd70, 1'b0);
    send_bin(24'd0, 1'b0);
    send_bin(24'd80, 1'b1);
  endtask

  // shallow curvature drives the offset past one bin either way
  task automatic test_offset_saturation();
    wait_idle();
    set_config(12'd2, 12'd2, $urandom(), 1'b0);
    send_bin(24'd0, 1'b0);
    send_bin(24'd100, 1'b0);
    send_bin(24'd101, 1'b0);
    send_bin(24'd103, 1'b1);
    send_bin(24'd0, 1'b0);
    send_bin(24'd103, 1'b0);
    send_bin(24'd101, 1'b0);
    send_bin(24'd100, 1'b1);
  endtask

  // result side holds off long enough for the input to back up
  task automatic test_output_backpressure();
    wait_idle();
    set_config(12'd1, 12'd2, $urandom(), 1'b0);
    idling = 1'b0;
    hold_ticket++;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < 3; i++) send_bin(MAG_W'($urandom()), i == 2);
    end
    idling = 1'b1;
  endtask

  task automatic test_random_spectra();
    int               items;
    int               spectra;
    int               len;
    int               pattern;
    int               centre;
    int               rise;
    int               fall;
    logic [BIN_W-1:0] low;
    logic [BIN_W-1:0] high;
    logic [31:0]      scale;
    logic [MAG_W-1:0] height;
    logic [MAG_W-1:0] mag;
    items   = 0;
    spectra = 0;
    while (items < 360 || spectra < 24) begin
      if (spectra % 6 == 0) begin
        wait_idle();
        idling = (spectra % 24) != 18;
        case ($urandom_range(0, 5))
          0: begin
            low  = '0;
            high = '1;
          end
          1: begin
            low  = BIN_W'($urandom_range(1, 12));
            high = BIN_W'($urandom_range(0, low - 1));
          end
          2: begin
            low  = '1;
            high = '1;
          end
          3: begin
            low  = BIN_W'($urandom_range(0, 4095));
            high = BIN_W'($urandom_range(0, 4095));
          end
          default: begin
            low  = BIN_W'($urandom_range(0, 10));
            high = low + BIN_W'($urandom_range(0, 20));
          end
        endcase
        case ($urandom_range(0, 3))
          0:       scale = '0;
          1:       scale = '1;
          default: scale = $urandom();
        endcase
        set_config(low, high, scale, $urandom_range(0, 3) == 0);
      end
      len     = $urandom_range(1, 24);
      pattern = $urandom_range(0, 3);
      centre  = $urandom_range(0, len - 1);
      rise    = $urandom_range(1, 3);
      fall    = $urandom_range(1, 3);
      height  = MAG_W'($urandom());
      for (int i = 0; i < len; i++) begin
        case (pattern)
          0: mag = MAG_W'($urandom());
          1: mag = (i < centre) ? height >> (rise * (centre - i)) : height >> (fall * (i - centre));
          2: mag = MAG_W'($urandom_range(0, 3));
          default: mag = '0;
        endcase
        send_bin(mag, i == len - 1);
      end
      items += len;
      spectra++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_edge_peaks();
    test_flat_and_empty();
    test_offset_saturation();
    test_output_backpressure();
    test_random_spectra();
    wait_idle();
    if (mismatch_count == 0 && expected_rpm_q.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
